@@ hw/rtl/lzsd_pkg.sv @@
`timescale 1ns / 1ps

package lzsd_pkg;

    // History window geometry
    localparam int WINDOW_DEPTH = 4096;
    localparam int WIN_AW       = 12;
    localparam int FILL_W       = 13;

    // Window contents before any byte is written
    localparam logic [7:0] SPACE_CHAR = 8'h20;

    // Command queue geometry
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = 1;
    localparam int Q_CNT_W = 2;

    // One decoded command handed from front to back
    typedef struct packed {
        logic              is_match;
        logic [7:0]        lit;
        logic [WIN_AW-1:0] pos;
        logic [3:0]        len_code;
    } cmd_t;

    // Back-end status seen by the top level
    typedef struct packed {
        logic              emitting;
        logic              at_last;
        logic [FILL_W-1:0] fill;
    } back_stat_t;

endpackage

@@ hw/rtl/lzsd_ram.sv @@
`timescale 1ns / 1ps

module lzsd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // One write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ hw/rtl/lzsd_front.sv @@
`timescale 1ns / 1ps

module lzsd_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [7:0]        in_byte,
    input  logic              q_full,
    output logic              push,
    output lzsd_pkg::cmd_t    push_cmd
);

    logic [7:0] flags_reg, flags_next;
    logic [3:0] consumed_reg, consumed_next;
    logic       awaiting_reg, awaiting_next;
    logic [7:0] hi_reg, hi_next;
    logic       accept;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;

    // Classify each accepted byte: flag, literal, token half
    always_comb
    begin
        flags_next        = flags_reg;
        consumed_next     = consumed_reg;
        awaiting_next     = awaiting_reg;
        hi_next           = hi_reg;
        push              = 1'b0;
        push_cmd.is_match = awaiting_reg;
        push_cmd.lit      = in_byte;
        push_cmd.pos      = {hi_reg, in_byte[7:4]};
        push_cmd.len_code = in_byte[3:0];
        if (accept)
        begin
            if (awaiting_reg)
            begin
                push          = 1'b1;
                awaiting_next = 1'b0;
                flags_next    = {1'b0, flags_reg[7:1]};
                consumed_next = consumed_reg + 4'd1;
            end
            else if (consumed_reg[3])
            begin
                // counter at 8 or above: this is a flag byte
                flags_next    = in_byte;
                consumed_next = 4'd0;
            end
            else if (flags_reg[0])
            begin
                push          = 1'b1;
                flags_next    = {1'b0, flags_reg[7:1]};
                consumed_next = consumed_reg + 4'd1;
            end
            else
            begin
                hi_next       = in_byte;
                awaiting_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flags_reg    <= 8'd0;
            consumed_reg <= 4'd8;
            awaiting_reg <= 1'b0;
            hi_reg       <= 8'd0;
        end
        else
        begin
            flags_reg    <= flags_next;
            consumed_reg <= consumed_next;
            awaiting_reg <= awaiting_next;
            hi_reg       <= hi_next;
        end
    end

endmodule

@@ hw/rtl/lzsd_cmd_fifo.sv @@
`timescale 1ns / 1ps

module lzsd_cmd_fifo (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  lzsd_pkg::cmd_t push_cmd,
    input  logic           pop,
    output logic           valid,
    output logic           full,
    output lzsd_pkg::cmd_t head
);

    lzsd_pkg::cmd_t                 entry_reg [lzsd_pkg::Q_DEPTH];
    logic [lzsd_pkg::Q_PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [lzsd_pkg::Q_PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [lzsd_pkg::Q_CNT_W-1:0]   count_reg, count_next;

    assign valid = (count_reg != '0);
    assign full  = (count_reg == lzsd_pkg::Q_CNT_W'(lzsd_pkg::Q_DEPTH));
    assign head  = entry_reg[rd_ptr_reg];

    // Pointer and occupancy update
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage, no reset needed
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

@@ hw/rtl/lzsd_back.sv @@
`timescale 1ns / 1ps

module lzsd_back #(
    parameter int LITERAL_LIMIT = 2
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cmd_valid,
    input  lzsd_pkg::cmd_t         cmd,
    output logic                   cmd_pop,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [7:0]             out_byte,
    output logic                   out_last,
    output lzsd_pkg::back_stat_t   stat
);

    localparam int MAX_RUN = 15 + LITERAL_LIMIT + 1;
    localparam int IDX_W   = $clog2(MAX_RUN);
    localparam int LEN_W   = $clog2(MAX_RUN + 1);
    localparam logic [LEN_W-1:0] RUN_BASE = LEN_W'(LITERAL_LIMIT + 1);
    localparam logic [lzsd_pkg::FILL_W-1:0] FILL_MAX =
        lzsd_pkg::FILL_W'(lzsd_pkg::WINDOW_DEPTH);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_EMIT
    } state_t;

    state_t                           state_reg, state_next;
    logic [lzsd_pkg::WIN_AW-1:0]      pos_reg, pos_next;
    logic [LEN_W-1:0]                 len_reg, len_next;
    logic [LEN_W-1:0]                 rd_idx_reg, rd_idx_next;
    logic                             pend_valid_reg, pend_valid_next;
    logic [IDX_W-1:0]                 pend_idx_reg, pend_idx_next;
    logic                             pend_blank_reg, pend_blank_next;
    logic [IDX_W-1:0]                 em_idx_reg, em_idx_next;
    logic [lzsd_pkg::WIN_AW-1:0]      wp_reg, wp_next;
    logic [lzsd_pkg::FILL_W-1:0]      fill_reg, fill_next;
    logic                             out_valid_reg, out_valid_next;
    logic [7:0]                       out_byte_reg, out_byte_next;
    logic                             out_last_reg, out_last_next;

    logic [7:0]                       stage_reg [MAX_RUN];
    logic                             out_free;
    logic                             at_last;
    logic                             ram_we;
    logic [7:0]                       ram_wdata;
    logic                             ram_re;
    logic [lzsd_pkg::WIN_AW-1:0]      ram_raddr;
    logic [7:0]                       ram_rdata;
    logic [7:0]                       stage_wdata;

    // History window
    lzsd_ram #(
        .WIDTH (8),
        .DEPTH (lzsd_pkg::WINDOW_DEPTH)
    ) u_window (
        .clk   (clk),
        .we    (ram_we),
        .waddr (wp_reg),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign out_free    = !out_valid_reg || out_ready;
    assign at_last     = ((LEN_W'(em_idx_reg) + LEN_W'(1)) == len_reg);
    assign ram_raddr   = pos_reg + lzsd_pkg::WIN_AW'(rd_idx_reg);
    // entries at or above the fill count were never written: read as space
    assign stage_wdata = pend_blank_reg ? lzsd_pkg::SPACE_CHAR : ram_rdata;

    // Sequencer: literal, match read phase, match emit phase
    always_comb
    begin
        state_next      = state_reg;
        pos_next        = pos_reg;
        len_next        = len_reg;
        rd_idx_next     = rd_idx_reg;
        pend_valid_next = 1'b0;
        pend_idx_next   = pend_idx_reg;
        pend_blank_next = pend_blank_reg;
        em_idx_next     = em_idx_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_byte_next   = out_byte_reg;
        out_last_next   = out_last_reg;
        cmd_pop         = 1'b0;
        ram_we          = 1'b0;
        ram_wdata       = stage_reg[em_idx_reg];
        ram_re          = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    if (cmd.is_match)
                    begin
                        cmd_pop     = 1'b1;
                        pos_next    = cmd.pos;
                        len_next    = LEN_W'(cmd.len_code) + RUN_BASE;
                        rd_idx_next = '0;
                        state_next  = ST_READ;
                    end
                    else if (out_free)
                    begin
                        cmd_pop        = 1'b1;
                        ram_we         = 1'b1;
                        ram_wdata      = cmd.lit;
                        out_valid_next = 1'b1;
                        out_byte_next  = cmd.lit;
                        out_last_next  = 1'b1;
                    end
                end
            end
            ST_READ:
            begin
                if (rd_idx_reg != len_reg)
                begin
                    ram_re          = 1'b1;
                    pend_valid_next = 1'b1;
                    pend_idx_next   = rd_idx_reg[IDX_W-1:0];
                    pend_blank_next = ({1'b0, ram_raddr} >= fill_reg);
                    rd_idx_next     = rd_idx_reg + LEN_W'(1);
                end
                else if (!pend_valid_reg)
                begin
                    em_idx_next = '0;
                    state_next  = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    ram_we         = 1'b1;
                    out_valid_next = 1'b1;
                    out_byte_next  = stage_reg[em_idx_reg];
                    out_last_next  = at_last;
                    if (at_last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        em_idx_next = em_idx_reg + IDX_W'(1);
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Window write pointer and saturating fill count
    always_comb
    begin
        wp_next   = wp_reg;
        fill_next = fill_reg;
        if (ram_we)
        begin
            wp_next = wp_reg + 1'b1;
            if (fill_reg != FILL_MAX)
            begin
                fill_next = fill_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            pos_reg        <= '0;
            len_reg        <= '0;
            rd_idx_reg     <= '0;
            pend_valid_reg <= 1'b0;
            pend_idx_reg   <= '0;
            pend_blank_reg <= 1'b0;
            em_idx_reg     <= '0;
            wp_reg         <= '0;
            fill_reg       <= '0;
            out_valid_reg  <= 1'b0;
            out_byte_reg   <= 8'd0;
            out_last_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            pos_reg        <= pos_next;
            len_reg        <= len_next;
            rd_idx_reg     <= rd_idx_next;
            pend_valid_reg <= pend_valid_next;
            pend_idx_reg   <= pend_idx_next;
            pend_blank_reg <= pend_blank_next;
            em_idx_reg     <= em_idx_next;
            wp_reg         <= wp_next;
            fill_reg       <= fill_next;
            out_valid_reg  <= out_valid_next;
            out_byte_reg   <= out_byte_next;
            out_last_reg   <= out_last_next;
        end
    end

    // Copy staging, filled one byte per cycle as read data returns
    always_ff @(posedge clk)
    begin
        if (pend_valid_reg)
        begin
            stage_reg[pend_idx_reg] <= stage_wdata;
        end
    end

    assign out_valid     = out_valid_reg;
    assign out_byte      = out_byte_reg;
    assign out_last      = out_last_reg;
    assign stat.emitting = (state_reg == ST_EMIT);
    assign stat.at_last  = at_last;
    assign stat.fill     = fill_reg;

endmodule

@@ hw/rtl/lzsd_stream_top_note.sv @@
`timescale 1ns / 1ps

// Output word flag used only to tag run boundaries for observation logic.
module lzsd_run_mark (
    input  logic clk,
    input  logic rst_n,
    input  logic word_done,
    input  logic word_last,
    output logic mid_run
);

    logic mid_run_reg, mid_run_next;

    // Set while a multi-word run is partly delivered
    always_comb
    begin
        mid_run_next = mid_run_reg;
        if (word_done)
        begin
            mid_run_next = !word_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mid_run_reg <= 1'b0;
        end
        else
        begin
            mid_run_reg <= mid_run_next;
        end
    end

    assign mid_run = mid_run_reg;

endmodule

@@ hw/rtl/lzss_stream_decoder.sv @@
`timescale 1ns / 1ps

// LZSS stream decoder, 4096-byte history window, flag-byte token format.
// Slave channel s_*: one compressed byte per word (flag, literal or token byte).
// Master channel m_*: one decompressed byte per word; m_tlast marks the last
// byte produced by one input word (a literal or the second byte of a token).
// The front end parses each input word as it is accepted and queues up to two
// literal or match commands; s_tready drops only while that queue is full.
// In the back end a literal is popped and written to the window and to the
// output register; a match of L bytes (L = 3..18 at the default) is popped,
// then read byte by byte through the single read port of the window into a
// staging buffer; once the last read byte has landed there, its bytes are
// emitted and written back one byte each.
// Flag bytes and first token bytes produce no output word.
// Output words come from a register: a literal appears in the cycle after the
// back end takes it, the first byte of a match once its staging is done; a stalled
// m_tready holds the word and the back end waits, while the front end keeps
// filling the queue.
// After reset the window reads as all spaces through a fill count, so there
// is no clearing pass and s_tready is high from the first cycle.
module lzss_stream_decoder #(
    parameter int LITERAL_LIMIT = 2
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,    // [7:0] in_byte
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,    // [7:0] out_byte
    output logic       m_tlast     // run_last
);

    logic                 q_full;
    logic                 push;
    lzsd_pkg::cmd_t       push_cmd;
    logic                 cmd_valid;
    logic                 cmd_pop;
    lzsd_pkg::cmd_t       cmd_head;
    lzsd_pkg::back_stat_t stat;
    logic                 out_free;
    logic                 mid_run;

    // Front end: parse flags and tokens
    lzsd_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_byte  (s_tdata),
        .q_full   (q_full),
        .push     (push),
        .push_cmd (push_cmd)
    );

    // Command queue between front and back
    lzsd_cmd_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (cmd_pop),
        .valid    (cmd_valid),
        .full     (q_full),
        .head     (cmd_head)
    );

    // Back end: window, staging and output register
    lzsd_back #(
        .LITERAL_LIMIT (LITERAL_LIMIT)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd       (cmd_head),
        .cmd_pop   (cmd_pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_byte  (m_tdata),
        .out_last  (m_tlast),
        .stat      (stat)
    );

    // Tracks partly delivered runs
    lzsd_run_mark u_run_mark (
        .clk       (clk),
        .rst_n     (rst_n),
        .word_done (m_tvalid && m_tready),
        .word_last (m_tlast),
        .mid_run   (mid_run)
    );

    assign out_free = !m_tvalid || m_tready;

    // Queue is only popped when it holds a command
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_pop |-> cmd_valid)
        else $error("command popped from empty queue");

    // Fill count never passes the window depth
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        stat.fill <= lzsd_pkg::FILL_W'(lzsd_pkg::WINDOW_DEPTH))
        else $error("window fill count overflow");

    // Emitting a non-final byte keeps the back end in the emit phase
    a_emit_continues: assert property (@(posedge clk) disable iff (!rst_n)
        stat.emitting && out_free && !stat.at_last |=> stat.emitting)
        else $error("match emit phase ended early");

    // A non-final byte taken is followed by the next byte at once
    a_run_gapless: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && !m_tlast |=> m_tvalid && mid_run)
        else $error("gap inside an output run");

endmodule
